// File: design/srs_pkg.sv
// srs_pkg: command, status and decision codes, the slot record and the
// sequencer states of the service restart supervisor
// no dependencies
package srs_pkg;

   typedef enum logic [2:0] {
      CMD_REGISTER   = 3'd0,
      CMD_UNREGISTER = 3'd1,
      CMD_SET_HB     = 3'd2,
      CMD_START      = 3'd3,
      CMD_HEARTBEAT  = 3'd4,
      CMD_EXIT       = 3'd5,
      CMD_EVALUATE   = 3'd6,
      CMD_UNKNOWN    = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_INVALID     = 3'd1,
      ST_NOT_FOUND   = 3'd2,
      ST_BUSY        = 3'd3,
      ST_NOT_RUNNING = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      DEC_CONTINUE = 3'd0,
      DEC_RESTART  = 3'd1,
      DEC_GIVE_UP  = 3'd2,
      DEC_ESCALATE = 3'd3,
      DEC_WAIT     = 3'd4
   } decision_type;

   localparam logic [1:0] POL_NEVER      = 2'd0;
   localparam logic [1:0] POL_ON_FAILURE = 2'd1;
   localparam logic [1:0] POL_ALWAYS     = 2'd2;

   // in-use lives in flops outside the memory
   typedef struct packed {
      logic        run;
      logic        gave;
      logic [1:0]  policy;
      logic [7:0]  limit;
      logic [7:0]  count;
      logic [63:0] window;
      logic [63:0] base;
      logic [63:0] cap;
      logic [63:0] hb;
      logic [63:0] started;
      logic [63:0] last_beat;
      logic [63:0] last_restart;
      logic [63:0] pending;
   } slot_rec_type;

   localparam int REC_W = $bits(slot_rec_type);

   typedef struct packed {
      logic        start;
      logic [63:0] base;
      logic [63:0] cap;
      logic [7:0]  count;
   } bo_req_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_CALC,
      S_EXIT2,
      S_BACK,
      S_EVAL2,
      S_OUT
   } state_type;

endpackage

// File: design/service_restart_supervisor.sv
// service_restart_supervisor: an item runs from accept through S_LOAD (slot read)
// and S_CALC to S_OUT, by way of S_EXIT2 for an exit that checks the restart budget
// or S_EVAL2 for an evaluate of a running or waiting slot, and of S_EXIT2 and S_BACK
// (at most 63 backoff doublings) for an exit that restarts; one item is in work at a
// time and the next is accepted in the cycle after its result is registered.
// Synchronous reset clears the in-use marks, the degraded flag and both counters.
module service_restart_supervisor #(
   parameter int SLOTS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_cmd,
   input  logic [3:0]  req_slot,
   input  logic [63:0] req_now,
   input  logic        req_exit_failed,
   input  logic [1:0]  req_policy,
   input  logic [7:0]  req_restart_limit,
   input  logic [63:0] req_health_window,
   input  logic [63:0] req_backoff_base,
   input  logic [63:0] req_backoff_cap,
   input  logic [63:0] req_heartbeat_interval,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [2:0]  rsp_decision,
   output logic [63:0] rsp_delay,
   output logic        rsp_decision_published,
   output logic        rsp_degraded_event,
   output logic        rsp_degraded,
   output logic [31:0] rsp_restart_count,
   output logic [31:0] rsp_giveup_count
);
   import srs_pkg::*;

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

   state_type state_ff, state_in;

   logic [SLOTS-1:0] used_vec_ff;
   logic [AW-1:0]    addr_ff;
   logic             slot_ok_ff;
   logic             used_ff;
   cmd_type          cmd_ff;
   logic [63:0]      now_ff;
   logic             failed_ff;
   logic [1:0]       pol_ff;
   logic [7:0]       lim_ff;
   logic [63:0]      window_ff, base_ff, cap_ff, hb_ff;

   slot_rec_type     rec_ff;
   slot_rec_type     rdata_rec;
   logic [REC_W-1:0] ram_rdata;
   logic             we_ff;
   logic             gt_ff;
   logic [63:0]      diff_ff;

   logic [2:0]       res_status_ff, res_decision_ff;
   logic [63:0]      res_delay_ff;
   logic             res_pub_ff, res_event_ff;

   logic             degraded_ff;
   logic [31:0]      restarts_ff, giveups_ff;

   logic             rsp_valid_ff;
   logic [2:0]       rsp_status_ff, rsp_decision_ff;
   logic [63:0]      rsp_delay_ff;
   logic             rsp_pub_ff, rsp_event_ff, rsp_degraded_ff;
   logic [31:0]      rsp_restarts_ff, rsp_giveups_ff;

   logic             req_take;
   logic             ram_we;
   logic             exit_long, eval_long;
   logic [7:0]       cnt_eff;
   logic             give_up;
   logic             bo_done;
   logic [63:0]      bo_result;
   bo_req_type       bo_req;

   srs_ram #(.WIDTH(REC_W), .DEPTH(SLOTS)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (addr_ff),
      .wdata (rec_ff),
      .raddr (AW'(req_slot)),
      .rdata (ram_rdata)
   );

   srs_backoff u_backoff (
      .clock  (clock),
      .reset  (reset),
      .req    (bo_req),
      .done   (bo_done),
      .result (bo_result)
   );

   assign rdata_rec = slot_rec_type'(ram_rdata);

   // exit and evaluate items that need a second wide step
   assign exit_long = cmd_ff == CMD_EXIT && used_ff && rec_ff.policy != POL_NEVER &&
                      !(rec_ff.policy == POL_ON_FAILURE && !failed_ff) && !rec_ff.gave;
   assign eval_long = cmd_ff == CMD_EVALUATE && used_ff &&
                      (rec_ff.run || (rec_ff.pending != 64'd0 && !rec_ff.gave));
   // health window refreshes the budget
   assign cnt_eff   = (gt_ff && diff_ff >= rec_ff.window) ? 8'd0 : rec_ff.count;
   assign give_up   = rec_ff.limit == 8'd0 || cnt_eff >= rec_ff.limit;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_LOAD;
         end
         S_LOAD:  state_in = S_CALC;
         S_CALC: begin
            priority if (exit_long) state_in = S_EXIT2;
            else if (eval_long)     state_in = S_EVAL2;
            else                    state_in = S_OUT;
         end
         S_EXIT2: state_in = give_up ? S_OUT : S_BACK;
         S_BACK: begin
            if (bo_done) state_in = S_OUT;
         end
         S_EVAL2: state_in = S_OUT;
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state machine outputs
   always_comb begin
      req_ready    = state_ff == S_IDLE;
      ram_we       = state_ff == S_OUT && we_ff;
      bo_req.start = state_ff == S_EXIT2 && !give_up;
      bo_req.base  = rec_ff.base;
      bo_req.cap   = rec_ff.cap;
      bo_req.count = cnt_eff + 8'd1;
   end

   assign req_take = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff     <= cmd_type'(req_cmd);
         addr_ff    <= AW'(req_slot);
         slot_ok_ff <= 32'(req_slot) < SLOTS;
         used_ff    <= (32'(req_slot) < SLOTS) && used_vec_ff[AW'(req_slot)];
         now_ff     <= req_now;
         failed_ff  <= req_exit_failed;
         pol_ff     <= req_policy;
         lim_ff     <= req_restart_limit;
         window_ff  <= req_health_window;
         base_ff    <= req_backoff_base;
         cap_ff     <= req_backoff_cap;
         hb_ff      <= req_heartbeat_interval;
      end
   end

   // slot datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         used_vec_ff <= '0;
         degraded_ff <= 1'b0;
         restarts_ff <= 32'd0;
         giveups_ff  <= 32'd0;
         we_ff       <= 1'b0;
      end else begin
         unique case (state_ff)
            S_LOAD: begin
               rec_ff          <= rdata_rec;
               we_ff           <= 1'b0;
               gt_ff           <= 1'b0;
               res_status_ff   <= ST_OK;
               res_decision_ff <= DEC_CONTINUE;
               res_delay_ff    <= 64'd0;
               res_pub_ff      <= 1'b0;
               res_event_ff    <= 1'b0;
            end
            S_CALC: begin
               if (cmd_ff == CMD_REGISTER) begin
                  if (!slot_ok_ff || base_ff == 64'd0 || pol_ff > POL_ALWAYS ||
                      (cap_ff != 64'd0 && cap_ff < base_ff)) begin
                     res_status_ff <= ST_INVALID;
                  end else if (used_ff) begin
                     res_status_ff <= ST_BUSY;
                  end else begin
                     used_vec_ff[addr_ff] <= 1'b1;
                     we_ff                <= 1'b1;
                     rec_ff.run           <= 1'b0;
                     rec_ff.gave          <= 1'b0;
                     rec_ff.policy        <= pol_ff;
                     rec_ff.limit         <= lim_ff;
                     rec_ff.count         <= 8'd0;
                     rec_ff.window        <= window_ff;
                     rec_ff.base          <= base_ff;
                     if (cap_ff != 64'd0) begin
                        rec_ff.cap <= cap_ff;
                     end else if (base_ff[63:59] != 5'd0) begin
                        rec_ff.cap <= '1;
                     end else begin
                        rec_ff.cap <= base_ff << 5;
                     end
                     rec_ff.hb           <= 64'd0;
                     rec_ff.started      <= 64'd0;
                     rec_ff.last_beat    <= 64'd0;
                     rec_ff.last_restart <= 64'd0;
                     rec_ff.pending      <= 64'd0;
                  end
               end else if (cmd_ff == CMD_UNKNOWN) begin
                  res_status_ff <= ST_INVALID;
               end else if (!used_ff) begin
                  res_status_ff <= (cmd_ff == CMD_EVALUATE) ? ST_INVALID : ST_NOT_FOUND;
               end else begin
                  unique case (cmd_ff)
                     CMD_UNREGISTER: used_vec_ff[addr_ff] <= 1'b0;
                     CMD_SET_HB: begin
                        rec_ff.hb <= hb_ff;
                        we_ff     <= 1'b1;
                     end
                     CMD_START: begin
                        rec_ff.run       <= 1'b1;
                        rec_ff.started   <= now_ff;
                        rec_ff.pending   <= 64'd0;
                        rec_ff.last_beat <= now_ff;
                        we_ff            <= 1'b1;
                     end
                     CMD_HEARTBEAT: begin
                        if (!rec_ff.run) begin
                           res_status_ff <= ST_NOT_RUNNING;
                        end else begin
                           rec_ff.last_beat <= now_ff;
                           we_ff            <= 1'b1;
                        end
                     end
                     CMD_EXIT: begin
                        rec_ff.run <= 1'b0;
                        we_ff      <= 1'b1;
                        if (rec_ff.policy == POL_NEVER ||
                            (rec_ff.policy == POL_ON_FAILURE && !failed_ff)) begin
                           res_pub_ff <= 1'b1;
                        end else if (rec_ff.gave) begin
                           res_decision_ff <= DEC_ESCALATE;
                           res_event_ff    <= !degraded_ff;
                           degraded_ff     <= 1'b1;
                        end else begin
                           gt_ff   <= rec_ff.window != 64'd0 && rec_ff.started != 64'd0 &&
                                      now_ff >= rec_ff.started;
                           diff_ff <= now_ff - rec_ff.started;
                        end
                     end
                     CMD_EVALUATE: begin
                        if (rec_ff.run) begin
                           gt_ff   <= now_ff > rec_ff.last_beat;
                           diff_ff <= now_ff - rec_ff.last_beat;
                        end else if (rec_ff.pending != 64'd0 && !rec_ff.gave) begin
                           // due time, wrapping
                           diff_ff <= rec_ff.last_restart + rec_ff.pending;
                        end else if (rec_ff.gave) begin
                           res_decision_ff <= DEC_GIVE_UP;
                        end
                     end
                     default: res_status_ff <= ST_INVALID;
                  endcase
               end
            end
            S_EXIT2: begin
               if (give_up) begin
                  rec_ff.count    <= cnt_eff;
                  rec_ff.gave     <= 1'b1;
                  res_decision_ff <= DEC_GIVE_UP;
                  res_pub_ff      <= 1'b1;
                  res_event_ff    <= !degraded_ff;
                  degraded_ff     <= 1'b1;
                  giveups_ff      <= giveups_ff + 32'd1;
               end else begin
                  rec_ff.count <= cnt_eff + 8'd1;
               end
            end
            S_BACK: begin
               if (bo_done) begin
                  rec_ff.pending      <= bo_result;
                  rec_ff.last_restart <= now_ff;
                  restarts_ff         <= restarts_ff + 32'd1;
                  res_decision_ff     <= DEC_RESTART;
                  res_delay_ff        <= bo_result;
                  res_pub_ff          <= 1'b1;
               end
            end
            S_EVAL2: begin
               if (rec_ff.run) begin
                  if (rec_ff.hb != 64'd0 && gt_ff && diff_ff > rec_ff.hb) begin
                     rec_ff.run      <= 1'b0;
                     we_ff           <= 1'b1;
                     res_decision_ff <= DEC_ESCALATE;
                     res_pub_ff      <= 1'b1;
                     res_event_ff    <= !degraded_ff;
                     degraded_ff     <= 1'b1;
                  end
               end else if (now_ff >= diff_ff) begin
                  rec_ff.pending  <= 64'd0;
                  we_ff           <= 1'b1;
                  res_decision_ff <= DEC_RESTART;
                  res_pub_ff      <= 1'b1;
               end else begin
                  res_decision_ff <= DEC_WAIT;
                  res_delay_ff    <= diff_ff - now_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_OUT && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_ff    <= 1'b1;
         rsp_status_ff   <= res_status_ff;
         rsp_decision_ff <= res_decision_ff;
         rsp_delay_ff    <= res_delay_ff;
         rsp_pub_ff      <= res_pub_ff;
         rsp_event_ff    <= res_event_ff;
         rsp_degraded_ff <= degraded_ff;
         rsp_restarts_ff <= restarts_ff;
         rsp_giveups_ff  <= giveups_ff;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_decision           = rsp_decision_ff;
   assign rsp_delay              = rsp_delay_ff;
   assign rsp_decision_published = rsp_pub_ff;
   assign rsp_degraded_event     = rsp_event_ff;
   assign rsp_degraded           = rsp_degraded_ff;
   assign rsp_restart_count      = rsp_restarts_ff;
   assign rsp_giveup_count       = rsp_giveups_ff;
endmodule

// File: design/srs_ram.sv
// srs_ram: generic single-write, single-read memory with registered read
// no dependencies
module srs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                     wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                     rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

// File: design/srs_backoff.sv
// srs_backoff: capped doubling of the restart delay, one doubling a cycle
// depends on srs_pkg
module srs_backoff (
   input  logic               clock,
   input  logic               reset,
   input  srs_pkg::bo_req_type req,
   output logic               done,
   output logic [63:0]        result
);
   import srs_pkg::*;

   logic        busy_ff;
   logic        done_ff;
   logic [63:0] b_ff;
   logic [7:0]  i_ff;
   logic [7:0]  count_ff;
   logic [63:0] cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff  <= 1'b1;
            b_ff     <= req.base;
            cap_ff   <= req.cap;
            count_ff <= req.count;
            i_ff     <= 8'd1;
         end else if (busy_ff) begin
            if (i_ff < count_ff && b_ff != 64'd0) begin
               if (b_ff > (cap_ff >> 1)) begin
                  b_ff    <= cap_ff;
                  busy_ff <= 1'b0;
                  done_ff <= 1'b1;
               end else begin
                  b_ff <= b_ff << 1;
                  i_ff <= i_ff + 8'd1;
               end
            end else begin
               if (cap_ff != 64'd0 && b_ff > cap_ff) begin
                  b_ff <= cap_ff;
               end
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done   = done_ff;
   assign result = b_ff;
endmodule
